// File: hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, action codes and payload structs for the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPW = 16;            // operand field width
    localparam int WW  = 2 * OPW + 2;   // signed working width of sums
    localparam int MW  = WW - 1;        // magnitude width
    localparam int NW  = OPW + 1;       // signed width of a reduced numerator
    localparam int PW  = 2 * OPW + 1;   // signed width of a cross product
    localparam int KW  = $clog2(MW + 1);
    localparam int CW  = $clog2(MW);
    localparam int RNW = 33;
    localparam int RDW = 31;

    typedef enum logic [2:0] {
        OP_NORM = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_CMP  = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]            action;
        logic signed [OPW-1:0] first_numerator;
        logic signed [OPW-1:0] first_denominator;
        logic signed [OPW-1:0] second_numerator;
        logic signed [OPW-1:0] second_denominator;
    } in_t;

    typedef struct packed {
        logic signed [RNW-1:0] result_numerator;
        logic [RDW-1:0]        result_denominator;
        logic                  less_than;
        logic                  equal_flag;
        logic                  error_flag;
    } out_t;

    typedef struct packed {
        op_t            op;
        logic           err;
        logic [OPW-1:0] an;
        logic [OPW-1:0] ad;
        logic [OPW-1:0] bn;
        logic [OPW-1:0] bd;
    } cmd_t;

    function automatic logic [WW-1:0] sext_op(logic [OPW-1:0] v);
        return {{(WW - OPW){v[OPW-1]}}, v};
    endfunction

    function automatic logic [MW-1:0] mag_w(logic [WW-1:0] v);
        logic [WW-1:0] t;
        t = v[WW-1] ? (~v + 1'b1) : v;
        return t[MW-1:0];
    endfunction

endpackage

// File: hw/rtl/rau_front.sv
// ----------------------------------------------------------------------------
// Rational unit front end
// Accepts a transaction, flags bad operands and actions, hands it to the queue.
// ----------------------------------------------------------------------------
module rau_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rau_pkg::in_t  item,
    output logic          busy,
    input  logic          q_full,
    output logic          push,
    output rau_pkg::cmd_t cmd
);

    logic          valid_reg;
    logic          valid_next;
    rau_pkg::cmd_t cmd_reg;
    rau_pkg::cmd_t cmd_next;
    logic          accept;

    assign accept = start & ~valid_reg;
    assign busy   = valid_reg;
    assign push   = valid_reg & ~q_full;
    assign cmd    = cmd_reg;

    always_comb
    begin
        cmd_next.op  = rau_pkg::op_t'(item.action);
        cmd_next.an  = item.first_numerator;
        cmd_next.ad  = item.first_denominator;
        cmd_next.bn  = item.second_numerator;
        cmd_next.bd  = item.second_denominator;
        cmd_next.err = (item.first_denominator == '0) || (item.second_denominator == '0)
                    || (item.action > 3'(rau_pkg::OP_CMP));
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: hw/rtl/rau_queue.sv
// ----------------------------------------------------------------------------
// Rational unit command queue
// Two-entry queue that decouples the front end from the execution engine.
// ----------------------------------------------------------------------------
module rau_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rau_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output rau_pkg::cmd_t rd_cmd
);

    rau_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full   = count_reg == 2'd2;
    assign valid  = count_reg != 2'd0;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: hw/rtl/rau_back.sv
// ----------------------------------------------------------------------------
// Rational unit execution engine
// Reduces both operands, then for all but normalize forms cross products and reduces or compares.
// ----------------------------------------------------------------------------
module rau_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  rau_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          done,
    output rau_pkg::out_t result
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_GCD   = 7'b0000100,
        S_DIVN  = 7'b0001000,
        S_DIVD  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_COMB  = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        PH_A = 3'b001,
        PH_B = 3'b010,
        PH_R = 3'b100
    } phase_t;

    localparam int OPW = rau_pkg::OPW;
    localparam int WW  = rau_pkg::WW;
    localparam int MW  = rau_pkg::MW;
    localparam int NW  = rau_pkg::NW;
    localparam int PW  = rau_pkg::PW;
    localparam int KW  = rau_pkg::KW;
    localparam int CW  = rau_pkg::CW;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic                done_reg, done_next;
    rau_pkg::cmd_t       cmd_reg, cmd_next;
    logic [WW-1:0]       num_reg, num_next;
    logic [WW-1:0]       den_reg, den_next;
    logic                neg_reg, neg_next;
    logic [MW-1:0]       x_reg, x_next;
    logic [MW-1:0]       y_reg, y_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [MW-1:0]       nm_reg, nm_next;
    logic [MW-1:0]       dm_reg, dm_next;
    logic [MW-1:0]       g_reg, g_next;
    logic [MW:0]         rem_reg, rem_next;
    logic [MW-1:0]       quo_reg, quo_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [MW-1:0]       qn_reg, qn_next;
    logic [NW-1:0]       n1_reg, n1_next;
    logic [OPW-1:0]      d1_reg, d1_next;
    logic [NW-1:0]       n2_reg, n2_next;
    logic [OPW-1:0]      d2_reg, d2_next;
    logic [PW-1:0]       p_reg [4];
    logic [PW-1:0]       p_next;
    logic [1:0]          mcnt_reg, mcnt_next;
    rau_pkg::out_t       res_reg, res_next;

    // Datapath pieces.
    logic [MW:0]         div_r2;
    logic [MW:0]         div_trial;
    logic [MW:0]         div_rem;
    logic [MW-1:0]       div_quo;
    logic [WW-1:0]       signed_q;
    logic [NW-1:0]       mul_a;
    logic [OPW-1:0]      mul_b;
    logic                mul_b_signed;
    logic [OPW-1:0]      mag_a;
    logic [OPW-1:0]      mag_b;
    logic                mul_neg;
    logic [2*OPW-1:0]    prod;
    logic [NW-1:0]       neg_a;
    logic [NW-1:0]       neg_b;
    logic [WW-1:0]       p0_w;
    logic [WW-1:0]       p1_w;
    logic [WW-1:0]       p2_w;
    logic [WW-1:0]       p3_w;
    rau_pkg::out_t       err_res;

    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        // One restoring divide step: quotient shifts in from the right.
        div_r2    = {rem_reg[MW-1:0], quo_reg[MW-1]};
        div_trial = div_r2 - {1'b0, g_reg};
        if (!div_trial[MW])
        begin
            div_rem = div_trial;
            div_quo = {quo_reg[MW-2:0], 1'b1};
        end
        else
        begin
            div_rem = div_r2;
            div_quo = {quo_reg[MW-2:0], 1'b0};
        end

        signed_q = neg_reg ? (WW'(0) - {1'b0, qn_reg}) : {1'b0, qn_reg};

        case (mcnt_reg)
            2'd0:
            begin
                mul_a = n1_reg; mul_b = d2_reg; mul_b_signed = 1'b0;
            end
            2'd1:
            begin
                mul_a = n2_reg; mul_b = d1_reg; mul_b_signed = 1'b0;
            end
            2'd2:
            begin
                mul_a = n1_reg; mul_b = n2_reg[OPW-1:0]; mul_b_signed = 1'b1;
            end
            default:
            begin
                mul_a = {1'b0, d1_reg}; mul_b = d2_reg; mul_b_signed = 1'b0;
            end
        endcase
        neg_a   = NW'(0) - mul_a;
        neg_b   = NW'(0) - n2_reg;
        mag_a   = mul_a[NW-1] ? neg_a[OPW-1:0] : mul_a[OPW-1:0];
        // The signed second factor is always n2, so its sign comes from n2.
        mag_b   = (mul_b_signed && n2_reg[NW-1]) ? neg_b[OPW-1:0] : mul_b;
        mul_neg = mul_a[NW-1] ^ (mul_b_signed & n2_reg[NW-1]);
        prod    = mag_a * mag_b;
        p_next  = mul_neg ? (PW'(0) - {1'b0, prod}) : {1'b0, prod};

        p0_w = {p_reg[0][PW-1], p_reg[0]};
        p1_w = {p_reg[1][PW-1], p_reg[1]};
        p2_w = {p_reg[2][PW-1], p_reg[2]};
        p3_w = {p_reg[3][PW-1], p_reg[3]};

        err_res.result_numerator   = '0;
        err_res.result_denominator = rau_pkg::RDW'(1);
        err_res.less_than          = 1'b0;
        err_res.equal_flag         = 1'b0;
        err_res.error_flag         = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cmd_next   = cmd_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        nm_next    = nm_reg;
        dm_next    = dm_reg;
        g_next     = g_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        qn_next    = qn_reg;
        n1_next    = n1_reg;
        d1_next    = d1_reg;
        n2_next    = n2_reg;
        d2_next    = d2_reg;
        mcnt_next  = mcnt_reg;
        res_next   = res_reg;
        pop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.err)
                    begin
                        res_next  = err_res;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_A;
                        num_next   = rau_pkg::sext_op(q_cmd.an);
                        den_next   = rau_pkg::sext_op(q_cmd.ad);
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                neg_next   = num_reg[WW-1] ^ den_reg[WW-1];
                x_next     = rau_pkg::mag_w(num_reg);
                y_next     = rau_pkg::mag_w(den_reg);
                nm_next    = rau_pkg::mag_w(num_reg);
                dm_next    = rau_pkg::mag_w(den_reg);
                k_next     = '0;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                // Binary GCD, one step a cycle; the denominator is never zero.
                if (x_reg == '0 || y_reg == '0)
                begin
                    g_next     = (x_reg | y_reg) << k_reg;
                    rem_next   = '0;
                    quo_next   = nm_reg;
                    cnt_next   = '0;
                    state_next = S_DIVN;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_reg >= y_reg)
                begin
                    x_next = x_reg - y_reg;
                end
                else
                begin
                    y_next = y_reg - x_reg;
                end
            end
            S_DIVN:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MW - 1))
                begin
                    qn_next    = div_quo;
                    rem_next   = '0;
                    quo_next   = dm_reg;
                    cnt_next   = '0;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MW - 1))
                begin
                    case (phase_reg)
                        PH_A:
                        begin
                            n1_next    = signed_q[NW-1:0];
                            d1_next    = div_quo[OPW-1:0];
                            phase_next = PH_B;
                            num_next   = rau_pkg::sext_op(cmd_reg.bn);
                            den_next   = rau_pkg::sext_op(cmd_reg.bd);
                            state_next = S_START;
                        end
                        PH_B:
                        begin
                            n2_next = signed_q[NW-1:0];
                            d2_next = div_quo[OPW-1:0];
                            if (cmd_reg.op == rau_pkg::OP_NORM)
                            begin
                                res_next.result_numerator   = rau_pkg::RNW'($signed(n1_reg));
                                res_next.result_denominator = rau_pkg::RDW'(d1_reg);
                                res_next.less_than          = 1'b0;
                                res_next.equal_flag         = 1'b0;
                                res_next.error_flag         = 1'b0;
                                done_next                   = 1'b1;
                                state_next                  = S_IDLE;
                            end
                            else
                            begin
                                mcnt_next  = '0;
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            res_next.result_numerator   = signed_q[rau_pkg::RNW-1:0];
                            res_next.result_denominator = div_quo[rau_pkg::RDW-1:0];
                            res_next.less_than          = 1'b0;
                            res_next.equal_flag         = 1'b0;
                            res_next.error_flag         = 1'b0;
                            done_next                   = 1'b1;
                            state_next                  = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd3)
                begin
                    state_next = S_COMB;
                end
            end
            S_COMB:
            begin
                phase_next = PH_R;
                state_next = S_START;
                case (cmd_reg.op)
                    rau_pkg::OP_ADD:
                    begin
                        num_next = p0_w + p1_w;
                        den_next = p3_w;
                    end
                    rau_pkg::OP_SUB:
                    begin
                        num_next = p0_w - p1_w;
                        den_next = p3_w;
                    end
                    rau_pkg::OP_MUL:
                    begin
                        num_next = p2_w;
                        den_next = p3_w;
                    end
                    rau_pkg::OP_DIV:
                    begin
                        num_next = p0_w;
                        den_next = p1_w;
                        if (n2_reg == '0)
                        begin
                            res_next   = err_res;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        res_next.result_numerator   = '0;
                        res_next.result_denominator = rau_pkg::RDW'(1);
                        res_next.less_than          = $signed(p_reg[0]) < $signed(p_reg[1]);
                        res_next.equal_flag         = (n1_reg == n2_reg) && (d1_reg == d2_reg);
                        res_next.error_flag         = 1'b0;
                        done_next                   = 1'b1;
                        state_next                  = S_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_A;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        k_reg    <= k_next;
        nm_reg   <= nm_next;
        dm_reg   <= dm_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        qn_reg   <= qn_next;
        n1_reg   <= n1_next;
        d1_reg   <= d1_next;
        n2_reg   <= n2_next;
        d2_reg   <= d2_next;
        mcnt_reg <= mcnt_next;
        res_reg  <= res_next;
        if (state_reg == S_MUL)
        begin
            p_reg[mcnt_reg] <= p_next;
        end
    end

endmodule

// File: hw/rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Reduces two fractions by their GCD, then normalizes, adds, subtracts,
// multiplies, divides or compares them and returns a reduced fraction or the compare flags.
// ----------------------------------------------------------------------------
//  Channel   Signals              Handshake
//  input     start, busy, item    taken when start is high and busy is low
//  result    done, result         valid for the single cycle done is high
//
//  An item reaches the engine through the front stage register and the queue.
//  Each GCD reduction is a binary GCD at one step a cycle plus two 33-step
//  restoring divides; arithmetic needs three of them and four cross products
//  on one shared multiplier, normalize needs two.
//  Flagged items leave the engine in the cycle after it takes them. A two-entry
//  queue lets up to three items wait; busy is high in the cycle after each
//  acceptance and stays high while the queue is full. The receiver cannot
//  stall. Reset clears all control.
module rational_arith_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::in_t  item,
    output logic          done,
    output rau_pkg::out_t result
);

    logic          q_full;
    logic          push;
    rau_pkg::cmd_t f_cmd;
    logic          pop;
    logic          q_valid;
    rau_pkg::cmd_t q_cmd;

    rau_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .q_full (q_full),
        .push   (push),
        .cmd    (f_cmd)
    );

    rau_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (f_cmd),
        .full   (q_full),
        .pop    (pop),
        .valid  (q_valid),
        .rd_cmd (q_cmd)
    );

    rau_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

    // A finished fraction always has a positive denominator.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.result_denominator != '0)
        else $error("result denominator is zero");

    // Errors always return zero over one with no compare flags.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.error_flag) |->
            (result.result_numerator == '0 && result.result_denominator == 31'd1
             && !result.less_than && !result.equal_flag))
        else $error("error result is not 0/1");

    // Strictly less and equal cannot both hold.
    a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.less_than && result.equal_flag))
        else $error("less_than and equal_flag both set");

    // The front never drops a held item: busy holds until the queue takes it.
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && q_full) |=> busy)
        else $error("held transaction lost");

endmodule
